@@ src/sts_pkg.sv @@
// Shared types, character codes, token kinds and helpers for the source token scanner.
// No dependencies; imported by source_token_scanner.
package sts_pkg;

    // Source size limit; the byte position saturates at min(MAX-1, 65535)
    localparam int unsigned MAX_SOURCE_BYTES = 65536;
    localparam int unsigned POS_CAP_INT =
        (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
    localparam logic [15:0] POS_CAP  = 16'(POS_CAP_INT);
    localparam logic [15:0] LINE_CAP = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // Token kinds
    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_NUM     = 5'd1;
    localparam logic [4:0] K_STR     = 5'd2;
    localparam logic [4:0] K_LPAR    = 5'd3;
    localparam logic [4:0] K_RPAR    = 5'd4;
    localparam logic [4:0] K_LBRC    = 5'd5;
    localparam logic [4:0] K_RBRC    = 5'd6;
    localparam logic [4:0] K_COMMA   = 5'd7;
    localparam logic [4:0] K_DOT     = 5'd8;
    localparam logic [4:0] K_MINUS   = 5'd9;
    localparam logic [4:0] K_PLUS    = 5'd10;
    localparam logic [4:0] K_SEMI    = 5'd11;
    localparam logic [4:0] K_SLASH   = 5'd12;
    localparam logic [4:0] K_STAR    = 5'd13;
    localparam logic [4:0] K_OPBASE  = 5'd14;
    localparam logic [4:0] K_UNTERM  = 5'd22;
    localparam logic [4:0] K_UNKNOWN = 5'd23;
    localparam logic [4:0] K_NONE    = 5'd0;

    // Operator codes held while waiting for a possible '='
    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_GT   = 2'd2;
    localparam logic [1:0] OP_LT   = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_STR,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_OP
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    // Length between two positions, floored at zero and capped at 16 bits
    function automatic logic [15:0] span(input logic [15:0] start, input logic [16:0] stop);
        logic [16:0] diff;
        begin
            diff = stop - {1'b0, start};
            if (stop < {1'b0, start}) begin
                span = 16'd0;
            end else if (diff[16]) begin
                span = 16'hFFFF;
            end else begin
                span = diff[15:0];
            end
        end
    endfunction

    // Single-character punctuation; K_NONE when the byte is not one
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        begin
            unique case (c)
                CH_LPAR:  punct_kind = K_LPAR;
                CH_RPAR:  punct_kind = K_RPAR;
                CH_LBRC:  punct_kind = K_LBRC;
                CH_RBRC:  punct_kind = K_RBRC;
                CH_COMMA: punct_kind = K_COMMA;
                CH_DOT:   punct_kind = K_DOT;
                CH_MINUS: punct_kind = K_MINUS;
                CH_PLUS:  punct_kind = K_PLUS;
                CH_SEMI:  punct_kind = K_SEMI;
                CH_STAR:  punct_kind = K_STAR;
                default:  punct_kind = K_NONE;
            endcase
        end
    endfunction

    // Operator code of ! = > < (only called on those bytes)
    function automatic logic [1:0] op_code(input logic [7:0] c);
        begin
            unique case (c)
                CH_BANG: op_code = OP_BANG;
                CH_EQ:   op_code = OP_EQ;
                CH_GT:   op_code = OP_GT;
                CH_LT:   op_code = OP_LT;
                default: op_code = OP_BANG;
            endcase
        end
    endfunction

    function automatic t_token mk_tok(input logic [4:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [15:0] line);
        begin
            mk_tok.kind  = kind;
            mk_tok.start = start;
            mk_tok.len   = len;
            mk_tok.line  = line;
            mk_tok.last  = 1'b0;
        end
    endfunction

endpackage

@@ src/source_token_scanner.sv @@
// Streaming source tokenizer: one byte per request in, tokens out through a 4-entry queue.
// Depends on sts_pkg.
//
//  channel | valid         | stall          | payload
//  --------+---------------+----------------+-----------------------------------------------
//  char in | i_char_valid  | o_char_stall   | i_char_byte
//  tok out | o_token_valid | i_token_stall  | o_token_kind, o_start_offset, o_token_length,
//          |               |                | o_line_number, o_last_of_run
//
// A byte is scanned in the cycle it is accepted and its tokens (0..3) land in the
// token queue at the next edge, so one byte per cycle flows while each byte gives at
// most one token and i_token_stall stays low. A byte that completes two or three tokens
// holds off further bytes: o_char_stall is high while the queue holds more than one token.
// Reset is synchronous; the queue empties and the scanner returns to line 1, offset 0.
// The end byte emits EOF and returns the scanner to that same state.
module source_token_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_char_valid,
    output logic                 o_char_stall,
    input  logic [7:0]           i_char_byte,
    output logic                 o_token_valid,
    input  logic                 i_token_stall,
    output logic [4:0]           o_token_kind,
    output logic [15:0]          o_start_offset,
    output logic [15:0]          o_token_length,
    output logic [15:0]          o_line_number,
    output logic                 o_last_of_run
);
    import sts_pkg::*;

    // Scanner state
    t_mode       r_mode, n_mode;
    logic [1:0]  r_pend, n_pend;
    logic [15:0] r_start, n_start;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_line, n_line;

    // Token queue
    t_token      r_q [4];
    logic [1:0]  r_head;
    logic [2:0]  r_cnt;

    t_token      n_tok [3];
    logic [1:0]  n_ntok;
    logic        blk_reset;
    logic        accept;
    logic        pop;
    logic [1:0]  tail;
    logic [15:0] dot_pos;
    logic [15:0] line_inc;
    logic        is_digit;

    assign accept   = i_char_valid && !o_char_stall;
    assign pop      = o_token_valid && !i_token_stall;
    assign tail     = r_head + r_cnt[1:0];
    assign dot_pos  = (r_pos != 16'd0) ? r_pos - 16'd1 : 16'd0;
    assign line_inc = (r_line < LINE_CAP) ? r_line + 16'd1 : r_line;
    assign is_digit = (i_char_byte >= CH_0) && (i_char_byte <= CH_9);

    // Next state and the tokens completed by the current byte
    always_comb begin
        logic [1:0] cnt;
        logic       run_idle;
        logic [4:0] pk;
        cnt       = 2'd0;
        run_idle  = 1'b0;
        blk_reset = 1'b0;
        pk        = punct_kind(i_char_byte);
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_start   = r_start;
        n_line    = r_line;
        for (int k = 0; k < 3; k++) begin
            n_tok[k] = mk_tok(K_NONE, 16'd0, 16'd0, 16'd0);
        end

        unique case (r_mode)
            MODE_INT, MODE_FRAC: begin
                if (is_digit) begin
                    // number continues
                end else if (r_mode == MODE_INT && i_char_byte == CH_DOT) begin
                    n_mode = MODE_DOT;
                end else begin
                    n_tok[cnt] = mk_tok(K_NUM, r_start, span(r_start, {1'b0, r_pos}), r_line);
                    cnt = cnt + 2'd1;
                    run_idle = 1'b1;
                end
            end
            MODE_DOT: begin
                if (is_digit) begin
                    n_mode = MODE_FRAC;
                end else begin
                    // dot with no fraction: number without it, then a dot token
                    n_tok[cnt] = mk_tok(K_NUM, r_start, span(r_start, {1'b0, dot_pos}), r_line);
                    cnt = cnt + 2'd1;
                    n_tok[cnt] = mk_tok(K_DOT, dot_pos, 16'd1, r_line);
                    cnt = cnt + 2'd1;
                    run_idle = 1'b1;
                end
            end
            MODE_STR: begin
                if (i_char_byte == CH_QUOTE) begin
                    n_tok[cnt] = mk_tok(K_STR, r_start,
                                        span(r_start, {1'b0, r_pos} + 17'd1), r_line);
                    cnt = cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end else if (i_char_byte == CH_NUL) begin
                    n_tok[cnt] = mk_tok(K_UNTERM, r_start, span(r_start, {1'b0, r_pos}), r_line);
                    cnt = cnt + 2'd1;
                    run_idle = 1'b1;
                end else if (i_char_byte == CH_LF) begin
                    n_line = line_inc;
                end
            end
            MODE_SLASH: begin
                if (i_char_byte == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    n_tok[cnt] = mk_tok(K_SLASH, r_start, 16'd1, r_line);
                    cnt = cnt + 2'd1;
                    run_idle = 1'b1;
                end
            end
            MODE_COMMENT: begin
                run_idle = (i_char_byte == CH_LF) || (i_char_byte == CH_NUL);
            end
            MODE_OP: begin
                if (i_char_byte == CH_EQ) begin
                    n_tok[cnt] = mk_tok(K_OPBASE + {2'b00, r_pend, 1'b1}, r_start, 16'd2, r_line);
                    cnt = cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_tok[cnt] = mk_tok(K_OPBASE + {2'b00, r_pend, 1'b0}, r_start, 16'd1, r_line);
                    cnt = cnt + 2'd1;
                    run_idle = 1'b1;
                end
            end
            MODE_IDLE: begin
                run_idle = 1'b1;
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        // Byte handled as the start of a new lexeme
        if (run_idle) begin
            n_mode = MODE_IDLE;
            case (i_char_byte) inside
                CH_NUL: begin
                    n_tok[cnt] = mk_tok(K_EOF, r_pos, 16'd0, r_line);
                    cnt = cnt + 2'd1;
                    blk_reset = 1'b1;
                end
                CH_SPACE, CH_CR, CH_TAB: begin
                end
                CH_LF: begin
                    n_line = line_inc;
                end
                [CH_0:CH_9]: begin
                    n_start = r_pos;
                    n_mode  = MODE_INT;
                end
                CH_QUOTE: begin
                    n_start = r_pos;
                    n_mode  = MODE_STR;
                end
                CH_SLASH: begin
                    n_start = r_pos;
                    n_mode  = MODE_SLASH;
                end
                CH_BANG, CH_EQ, CH_GT, CH_LT: begin
                    n_start = r_pos;
                    n_pend  = op_code(i_char_byte);
                    n_mode  = MODE_OP;
                end
                default: begin
                    n_tok[cnt] = mk_tok((pk != K_NONE) ? pk : K_UNKNOWN, r_pos, 16'd1, r_line);
                    cnt = cnt + 2'd1;
                end
            endcase
        end

        // End byte returns the scanner state to its reset values
        if (blk_reset) begin
            n_mode  = MODE_IDLE;
            n_pend  = OP_BANG;
            n_start = 16'd0;
            n_line  = 16'd1;
            n_pos   = 16'd0;
        end else begin
            n_pos = (r_pos < POS_CAP) ? r_pos + 16'd1 : r_pos;
        end

        if (cnt != 2'd0) begin
            n_tok[cnt - 2'd1].last = 1'b1;
        end
        n_ntok = cnt;
    end

    // Scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= OP_BANG;
            r_start <= 16'd0;
            r_pos   <= 16'd0;
            r_line  <= 16'd1;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
        end
    end

    // Token queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_head <= r_head + {1'b0, pop};
            r_cnt  <= r_cnt + (accept ? {1'b0, n_ntok} : 3'd0) - {2'b00, pop};
        end
    end

    // Token queue storage, written at the tail
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < n_ntok) begin
                    r_q[tail + 2'(k)] <= n_tok[k];
                end
            end
        end
    end

    // Room for a full three-token run is needed before taking a byte
    assign o_char_stall   = (r_cnt > 3'd1);
    assign o_token_valid  = (r_cnt != 3'd0);
    assign o_token_kind   = r_q[r_head].kind;
    assign o_start_offset = r_q[r_head].start;
    assign o_token_length = r_q[r_head].len;
    assign o_line_number  = r_q[r_head].line;
    assign o_last_of_run  = r_q[r_head].last;

endmodule

@@ sim/source_token_scanner_test.sv @@
// Self-checking testbench for source_token_scanner: byte stream in, tokens out.
// Depends on sts_pkg and source_token_scanner; carries its own scanner predictor.
`timescale 1ns / 100ps

module source_token_scanner_test;
    import sts_pkg::*;

    // Extra character codes used by the stimulus
    localparam logic [7:0] CH_TOP      = 8'hFF;
    localparam logic [7:0] CH_LETTER_X = 8'h78;
    localparam logic [4:0] K_BANG_EQ   = K_OPBASE + 5'd1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_char_valid = 1'b0;
    logic        o_char_stall;
    logic [7:0]  i_char_byte = 8'h00;
    logic        o_token_valid;
    logic        i_token_stall = 1'b0;
    logic [4:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic [15:0] o_line_number;
    logic        o_last_of_run;

    source_token_scanner i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (i_char_valid),
        .o_char_stall   (o_char_stall),
        .i_char_byte    (i_char_byte),
        .o_token_valid  (o_token_valid),
        .i_token_stall  (i_token_stall),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed stimulus row; tok is used only when typed is set
    typedef struct {
        logic [7:0] c;
        bit         typed;
        t_token     tok;
    } t_stim_row;

    t_token    tokens_due[$];
    t_token    run_tokens[$];
    t_stim_row stim_rows[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        bytes_counted = 0;

    // Predictor state
    t_mode       scan_st;
    logic [1:0]  held_op;
    logic [15:0] lex_start;
    logic [15:0] cur_pos;
    logic [15:0] cur_line;

    function automatic void clear_scanner();
        scan_st   = MODE_IDLE;
        held_op   = OP_BANG;
        lex_start = 16'd0;
        cur_pos   = 16'd0;
        cur_line  = 16'd1;
    endfunction

    function automatic void bump_line();
        if (cur_line < LINE_CAP) cur_line = cur_line + 16'd1;
    endfunction

    // Distance between positions, floored at 0, capped at 16 bits
    function automatic logic [15:0] span_len(input logic [15:0] from_pos,
                                             input logic [16:0] to_pos);
        logic [16:0] d;
        if (to_pos < {1'b0, from_pos}) return 16'd0;
        d = to_pos - {1'b0, from_pos};
        return d[16] ? 16'hFFFF : d[15:0];
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic void put_token(input logic [4:0] kind, input logic [15:0] start,
                                      input logic [15:0] len);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = cur_line;
        t.last  = 1'b0;
        run_tokens.push_back(t);
    endfunction

    // Byte seen with nothing pending; returns 1 when the end byte reset the scanner
    function automatic bit idle_scan(input logic [7:0] c);
        scan_st = MODE_IDLE;
        case (c)
            CH_NUL: begin
                put_token(K_EOF, cur_pos, 16'd0);
                clear_scanner();
                return 1'b1;
            end
            CH_SPACE, CH_CR, CH_TAB: begin
            end
            CH_LF:    bump_line();
            CH_QUOTE: begin lex_start = cur_pos; scan_st = MODE_STR; end
            CH_SLASH: begin lex_start = cur_pos; scan_st = MODE_SLASH; end
            CH_BANG:  begin lex_start = cur_pos; held_op = OP_BANG; scan_st = MODE_OP; end
            CH_EQ:    begin lex_start = cur_pos; held_op = OP_EQ; scan_st = MODE_OP; end
            CH_GT:    begin lex_start = cur_pos; held_op = OP_GT; scan_st = MODE_OP; end
            CH_LT:    begin lex_start = cur_pos; held_op = OP_LT; scan_st = MODE_OP; end
            CH_LPAR:  put_token(K_LPAR, cur_pos, 16'd1);
            CH_RPAR:  put_token(K_RPAR, cur_pos, 16'd1);
            CH_LBRC:  put_token(K_LBRC, cur_pos, 16'd1);
            CH_RBRC:  put_token(K_RBRC, cur_pos, 16'd1);
            CH_COMMA: put_token(K_COMMA, cur_pos, 16'd1);
            CH_DOT:   put_token(K_DOT, cur_pos, 16'd1);
            CH_MINUS: put_token(K_MINUS, cur_pos, 16'd1);
            CH_PLUS:  put_token(K_PLUS, cur_pos, 16'd1);
            CH_SEMI:  put_token(K_SEMI, cur_pos, 16'd1);
            CH_STAR:  put_token(K_STAR, cur_pos, 16'd1);
            default: begin
                if (is_digit(c)) begin
                    lex_start = cur_pos;
                    scan_st   = MODE_INT;
                end else begin
                    put_token(K_UNKNOWN, cur_pos, 16'd1);
                end
            end
        endcase
        return 1'b0;
    endfunction

    // Advance the predictor by one accepted byte; tokens land in run_tokens
    function automatic void scan_byte(input logic [7:0] c);
        logic [15:0] pos;
        logic [15:0] dotpos;
        bit          ended;
        pos   = cur_pos;
        ended = 1'b0;
        run_tokens.delete();
        case (scan_st)
            MODE_INT: begin
                if (c == CH_DOT) begin
                    scan_st = MODE_DOT;
                end else if (!is_digit(c)) begin
                    put_token(K_NUM, lex_start, span_len(lex_start, {1'b0, pos}));
                    ended = idle_scan(c);
                end
            end
            MODE_DOT: begin
                if (is_digit(c)) begin
                    scan_st = MODE_FRAC;
                end else begin
                    // number without its dot, then the dot on its own
                    dotpos = (pos != 16'd0) ? pos - 16'd1 : 16'd0;
                    put_token(K_NUM, lex_start, span_len(lex_start, {1'b0, dotpos}));
                    put_token(K_DOT, dotpos, 16'd1);
                    ended = idle_scan(c);
                end
            end
            MODE_FRAC: begin
                if (!is_digit(c)) begin
                    put_token(K_NUM, lex_start, span_len(lex_start, {1'b0, pos}));
                    ended = idle_scan(c);
                end
            end
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    put_token(K_STR, lex_start, span_len(lex_start, {1'b0, pos} + 17'd1));
                    scan_st = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    put_token(K_UNTERM, lex_start, span_len(lex_start, {1'b0, pos}));
                    ended = idle_scan(c);
                end else if (c == CH_LF) begin
                    bump_line();
                end
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_st = MODE_COMMENT;
                end else begin
                    put_token(K_SLASH, lex_start, 16'd1);
                    ended = idle_scan(c);
                end
            end
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_NUL) ended = idle_scan(c);
            end
            MODE_OP: begin
                if (c == CH_EQ) begin
                    put_token(K_OPBASE + {2'b00, held_op, 1'b1}, lex_start, 16'd2);
                    scan_st = MODE_IDLE;
                end else begin
                    put_token(K_OPBASE + {2'b00, held_op, 1'b0}, lex_start, 16'd1);
                    ended = idle_scan(c);
                end
            end
            default: ended = idle_scan(c);
        endcase
        if (!ended && cur_pos < POS_CAP) cur_pos = cur_pos + 16'd1;
    endfunction

    // Move the predicted tokens of one byte to the expected list, marking the last
    function automatic void queue_run();
        t_token t;
        for (int i = 0; i < run_tokens.size(); i++) begin
            t = run_tokens[i];
            t.last = (i == run_tokens.size() - 1);
            tokens_due.push_back(t);
        end
    endfunction

    function automatic t_stim_row byte_row(input logic [7:0] c);
        t_stim_row r;
        r.c     = c;
        r.typed = 1'b0;
        r.tok   = '0;
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic [7:0] c, input logic [4:0] kind,
                                              input logic [15:0] start, input logic [15:0] len,
                                              input logic [15:0] line);
        t_stim_row r;
        r.c         = c;
        r.typed     = 1'b1;
        r.tok.kind  = kind;
        r.tok.start = start;
        r.tok.len   = len;
        r.tok.line  = line;
        r.tok.last  = 1'b1;
        return r;
    endfunction

    // Present one byte request, with random idle cycles ahead of it; returns at acceptance
    task automatic offer_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_char_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_char_valid <= 1'b1;
        i_char_byte  <= b;
        do @(posedge i_clk); while (o_char_stall);
    endtask

    task automatic feed(input logic [7:0] b);
        offer_byte(b);
        scan_byte(b);
        queue_run();
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 10))
            0:       return CH_LPAR;
            1:       return CH_RPAR;
            2:       return CH_LBRC;
            3:       return CH_RBRC;
            4:       return CH_COMMA;
            5:       return CH_DOT;
            6:       return CH_MINUS;
            7:       return CH_PLUS;
            8:       return CH_SEMI;
            9:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return CH_BANG;
            1:       return CH_EQ;
            2:       return CH_GT;
            default: return CH_LT;
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Any nonzero byte other than the given terminator
    function automatic logic [7:0] rand_body(input logic [7:0] stop_ch);
        logic [7:0] b;
        if ($urandom_range(0, 6) == 0) return CH_LF == stop_ch ? CH_SPACE : CH_LF;
        b = 8'($urandom_range(1, 255));
        return (b == stop_ch) ? CH_SPACE : b;
    endfunction

    // One random lexeme: mostly well formed, some noise and broken ones
    task automatic feed_random_lexeme();
        logic [7:0] lex[$];
        int         pick;
        int         n;
        pick   = $urandom_range(0, 99);
        if (pick < 20) begin
            n = $urandom_range(1, 4);
            repeat (n) lex.push_back(rand_digit());
            if ($urandom_range(0, 9) < 4) begin
                lex.push_back(CH_DOT);
                if ($urandom_range(0, 3) != 0) begin
                    n = $urandom_range(1, 3);
                    repeat (n) lex.push_back(rand_digit());
                end
            end
        end else if (pick < 30) begin
            lex.push_back(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) lex.push_back(rand_body(CH_QUOTE));
            lex.push_back(CH_QUOTE);
        end else if (pick < 38) begin
            lex.push_back(CH_SLASH);
            lex.push_back(CH_SLASH);
            n = $urandom_range(0, 6);
            repeat (n) lex.push_back(rand_body(CH_LF));
            lex.push_back(($urandom_range(0, 4) == 0) ? CH_NUL : CH_LF);
        end else if (pick < 53) begin
            lex.push_back(rand_op());
            if ($urandom_range(0, 1) == 1) lex.push_back(CH_EQ);
        end else if (pick < 68) begin
            lex.push_back(rand_punct());
        end else if (pick < 81) begin
            n = $urandom_range(1, 3);
            repeat (n) lex.push_back(rand_space());
        end else if (pick < 90) begin
            lex.push_back(8'($urandom_range(1, 255)));
        end else if (pick < 94) begin
            lex.push_back(CH_NUL);
        end else if (pick < 97) begin
            // string cut off by the end byte
            lex.push_back(CH_QUOTE);
            n = $urandom_range(0, 4);
            repeat (n) lex.push_back(rand_body(CH_QUOTE));
            lex.push_back(CH_NUL);
        end else begin
            // digits and a dot with no fraction after it
            n = $urandom_range(1, 3);
            repeat (n) lex.push_back(rand_digit());
            lex.push_back(CH_DOT);
            lex.push_back(($urandom_range(0, 1) == 1) ? rand_punct() : CH_SPACE);
        end
        foreach (lex[i]) feed(lex[i]);
        bytes_counted += lex.size();
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 100) $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Token monitor: compare each accepted token with the oldest expectation
    always @(posedge i_clk) begin : token_check
        t_token want;
        if (i_rst_n && o_token_valid && !i_token_stall) begin
            if (tokens_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 100)
                    $error("unexpected token: kind %0d offset %0d", o_token_kind,
                           o_start_offset);
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", 16'(want.kind), 16'(o_token_kind));
                check_field("start_offset", want.start, o_start_offset);
                check_field("token_length", want.len, o_token_length);
                check_field("line_number", want.line, o_line_number);
                check_field("last_of_run", 16'(want.last), 16'(o_last_of_run));
            end
        end
    end

    // Token sink: random stalls plus one long hold-off to fill the block
    initial begin : token_sink
        int cycle_no;
        int hold_left;
        cycle_no  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) cycle_no++;
            if (cycle_no == 150) hold_left = 80;
            if (hold_left > 0) begin
                i_token_stall <= 1'b1;
                hold_left--;
            end else begin
                i_token_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Byte source and run control
    initial begin
        clear_scanner();

        // Directed bytes; positions and lines follow on from row to row
        stim_rows.push_back(checked_row(CH_NUL, K_EOF, 16'd0, 16'd0, 16'd1));
        stim_rows.push_back(checked_row(CH_TOP, K_UNKNOWN, 16'd0, 16'd1, 16'd1));
        stim_rows.push_back(checked_row(CH_LPAR, K_LPAR, 16'd1, 16'd1, 16'd1));
        stim_rows.push_back(byte_row(CH_0));
        stim_rows.push_back(byte_row(CH_0 + 8'd2));
        stim_rows.push_back(byte_row(CH_DOT));
        stim_rows.push_back(byte_row(CH_RPAR));      // number, dot and paren at once
        stim_rows.push_back(byte_row(CH_QUOTE));
        stim_rows.push_back(byte_row(CH_LF));        // newline inside a string
        stim_rows.push_back(byte_row(CH_QUOTE));
        stim_rows.push_back(byte_row(CH_SLASH));
        stim_rows.push_back(byte_row(CH_STAR));      // lone slash
        stim_rows.push_back(byte_row(CH_SLASH));
        stim_rows.push_back(byte_row(CH_SLASH));
        stim_rows.push_back(byte_row(CH_LETTER_X));
        stim_rows.push_back(byte_row(CH_LF));
        stim_rows.push_back(byte_row(CH_BANG));
        stim_rows.push_back(checked_row(CH_EQ, K_BANG_EQ, 16'd15, 16'd2, 16'd3));
        stim_rows.push_back(byte_row(CH_LT));
        stim_rows.push_back(byte_row(CH_9));
        stim_rows.push_back(byte_row(CH_DOT));
        stim_rows.push_back(byte_row(CH_0 + 8'd5));
        stim_rows.push_back(byte_row(CH_QUOTE));
        stim_rows.push_back(byte_row(CH_NUL));       // unterminated string, then EOF

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct = 9;
        recv_idle_pct = 74;
        foreach (stim_rows[i]) begin
            offer_byte(stim_rows[i].c);
            scan_byte(stim_rows[i].c);
            if (stim_rows[i].typed) tokens_due.push_back(stim_rows[i].tok);
            else queue_run();
        end
        while (bytes_counted < 140) feed_random_lexeme();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 74;
        recv_idle_pct = 9;
        while (bytes_counted < 280) feed_random_lexeme();

        // Full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_counted < 400) feed_random_lexeme();

        // Flush whatever is pending
        feed(CH_NUL);
        i_char_valid <= 1'b0;

        // Drain
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && tokens_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
